/* hw/rtl/weighted_plane_normal_equations_unit_defines.svh */
// ----------------------------------------------------------------------------
// Weighted plane normal equations: assertion macros
// Concurrent assertion shorthands clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_PLANE_NORMAL_EQUATIONS_UNIT_DEFINES_SVH
`define WEIGHTED_PLANE_NORMAL_EQUATIONS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define WPNE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define WPNE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WPNE_ASSERT_IMP(lbl, ante, cons, msg)
`define WPNE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/wpne_pkg.sv */
// ----------------------------------------------------------------------------
// Weighted plane normal equations: shared package
// Word types for points, results and the internal queue, plus default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package wpne_pkg;

	localparam int WPNE_ROM_DEPTH     = 1024;
	localparam int WPNE_FRACTION_BITS = 16;
	localparam int WPNE_QUEUE_DEPTH   = 4;

	// Widest weight over the supported fraction widths.
	localparam int WEIGHT_W = 25;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic               last_point;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] h_00;
		logic signed [63:0] h_01;
		logic signed [63:0] h_02;
		logic signed [63:0] h_11;
		logic signed [63:0] h_12;
		logic signed [63:0] h_22;
		logic signed [63:0] g_0;
		logic signed [63:0] g_1;
		logic signed [63:0] g_2;
		logic               overflowed;
	} out_word_t;

	typedef struct packed {
		in_word_t              pt;
		logic [WEIGHT_W-1:0]   weight;
	} q_item_t;

	typedef struct packed {
		logic emit;
		logic stall;
	} back_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/weighted_plane_normal_equations_unit.sv */
// A point marked last goes through the front stages, the queue and the back stages to its result word.
// Throughput: one point per cycle while the back end is not stalled by an unread result word.
// The back end stalls only while a finished result word waits unread; the queue
// then fills and full rises. Reset is asynchronous and clears the accumulators,
// the overflow flag, the queue and all valid bits; the weight table is constant.
// ----------------------------------------------------------------------------
// Weighted plane normal equations unit
// Accumulates robust-weighted normal equations of a height-plane fit per point set.
// ----------------------------------------------------------------------------
`default_nettype none
`include "weighted_plane_normal_equations_unit_defines.svh"

module weighted_plane_normal_equations_unit
	import wpne_pkg::*;
#(
	parameter int WEIGHT_ROM_DEPTH = WPNE_ROM_DEPTH,
	parameter int FRACTION_BITS    = WPNE_FRACTION_BITS,
	parameter int QUEUE_DEPTH      = WPNE_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_word_t  point,
	output logic      empty,
	input  logic      pop,
	output out_word_t sums
);

	q_item_t    q_wr, q_rd;
	logic       q_push, q_pop, q_full, q_empty;
	back_stat_t back_stat;

	wpne_front #(
		.WEIGHT_ROM_DEPTH(WEIGHT_ROM_DEPTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.point(point),
		.q_push(q_push),
		.q_item(q_wr),
		.q_full(q_full)
	);

	wpne_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(q_push),
		.wr_data(q_wr),
		.rd(q_pop),
		.rd_data(q_rd),
		.full(q_full),
		.empty(q_empty)
	);

	wpne_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_item(q_rd),
		.q_pop(q_pop),
		.pop(pop),
		.empty(empty),
		.sums(sums),
		.stat(back_stat)
	);

	`WPNE_ASSERT_IMP(a_queue_state, q_full, !q_empty, "Queue reports full and empty together.")
	`WPNE_ASSERT_IMP(a_emit_slot, back_stat.emit, empty || pop, "Result word overwritten unread.")
	`WPNE_ASSERT_NXT(a_emit_shown, back_stat.emit, !empty, "Emitted result word not shown.")
	`WPNE_ASSERT_IMP(a_stall_cause, back_stat.stall, !empty && !pop, "Back end stalled without cause.")

endmodule

`default_nettype wire

/* hw/rtl/wpne_front.sv */
// ----------------------------------------------------------------------------
// Weighted plane normal equations: front end
// Registers each point, squares the residual, scales it to a table address and
// reads the robust weight, then pushes the point with its weight to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wpne_front
	import wpne_pkg::*;
#(
	parameter int WEIGHT_ROM_DEPTH = WPNE_ROM_DEPTH,
	parameter int FRACTION_BITS    = WPNE_FRACTION_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_word_t point,
	output logic     q_push,
	output q_item_t  q_item,
	input  logic     q_full
);

	localparam int WW = FRACTION_BITS + 1;
	localparam int AW = $clog2(WEIGHT_ROM_DEPTH);
	localparam int DW = $clog2(WEIGHT_ROM_DEPTH + 1);
	localparam int QW = FRACTION_BITS + 4;

	// Entry k holds exp(-16k/depth); the step ratio comes from a Taylor series.
	localparam logic [63:0] D64    = 64'(WEIGHT_ROM_DEPTH);
	localparam logic [63:0] TAY_0  = 64'd1 << 48;
	localparam logic [63:0] TAY_1  = (TAY_0 * 64'd16) / (D64 * 64'd1);
	localparam logic [63:0] TAY_2  = (TAY_1 * 64'd16) / (D64 * 64'd2);
	localparam logic [63:0] TAY_3  = (TAY_2 * 64'd16) / (D64 * 64'd3);
	localparam logic [63:0] TAY_4  = (TAY_3 * 64'd16) / (D64 * 64'd4);
	localparam logic [63:0] TAY_5  = (TAY_4 * 64'd16) / (D64 * 64'd5);
	localparam logic [63:0] TAY_6  = (TAY_5 * 64'd16) / (D64 * 64'd6);
	localparam logic [63:0] TAY_7  = (TAY_6 * 64'd16) / (D64 * 64'd7);
	localparam logic [63:0] TAY_8  = (TAY_7 * 64'd16) / (D64 * 64'd8);
	localparam logic [63:0] TAY_9  = (TAY_8 * 64'd16) / (D64 * 64'd9);
	localparam logic [63:0] TAY_10 = (TAY_9 * 64'd16) / (D64 * 64'd10);
	localparam logic [63:0] TAY_11 = (TAY_10 * 64'd16) / (D64 * 64'd11);
	localparam logic [63:0] TAY_12 = (TAY_11 * 64'd16) / (D64 * 64'd12);
	localparam logic [63:0] TAY_13 = (TAY_12 * 64'd16) / (D64 * 64'd13);
	localparam logic [63:0] TAY_14 = (TAY_13 * 64'd16) / (D64 * 64'd14);
	localparam logic [63:0] TAY_15 = (TAY_14 * 64'd16) / (D64 * 64'd15);
	localparam logic [63:0] TAY_16 = (TAY_15 * 64'd16) / (D64 * 64'd16);
	localparam logic [63:0] TAY_17 = (TAY_16 * 64'd16) / (D64 * 64'd17);
	localparam logic [63:0] TAY_18 = (TAY_17 * 64'd16) / (D64 * 64'd18);
	localparam logic [63:0] TAY_19 = (TAY_18 * 64'd16) / (D64 * 64'd19);
	localparam logic [63:0] TAY_20 = (TAY_19 * 64'd16) / (D64 * 64'd20);
	localparam logic [63:0] SERIES = TAY_0 - TAY_1 + TAY_2 - TAY_3 + TAY_4 - TAY_5
		+ TAY_6 - TAY_7 + TAY_8 - TAY_9 + TAY_10 - TAY_11 + TAY_12 - TAY_13
		+ TAY_14 - TAY_15 + TAY_16 - TAY_17 + TAY_18 - TAY_19 + TAY_20;
	localparam logic [63:0] STEP_R = (SERIES + (64'd1 << 15)) >> 16;

	typedef logic [WW-1:0] rom_t [WEIGHT_ROM_DEPTH];

	function automatic rom_t build_rom();
		rom_t        tab;
		logic [63:0] v;
		v = 64'd1 << 32;
		for (int k = 0; k < WEIGHT_ROM_DEPTH; k++) begin
			if (k > 0) begin
				v = (v * STEP_R + (64'd1 << 31)) >> 32;
			end
			tab[k] = WW'((v + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS));
		end
		return tab;
	endfunction

	localparam rom_t WROM = build_rom();

	logic                 adv;
	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	in_word_t             pt_s1, pt_s2, pt_s3, pt_s4;
	logic signed [63:0]   zz_s2;
	logic [QW+DW-1:0]     scaled;
	logic [AW-1:0]        idx_s3;
	logic                 inr_s3, inr_s4;
	logic [WW-1:0]        rom_s4;

	assign adv    = !(vld_s4 && q_full);
	assign full   = !adv;
	assign q_push = vld_s4 && !q_full;
	assign scaled = zz_s2[2*FRACTION_BITS+3:FRACTION_BITS] * DW'(WEIGHT_ROM_DEPTH);

	assign q_item.pt     = pt_s4;
	assign q_item.weight = inr_s4 ? WEIGHT_W'(rom_s4) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= push;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s1  <= point;
			pt_s2  <= pt_s1;
			zz_s2  <= pt_s1.pz * pt_s1.pz;
			pt_s3  <= pt_s2;
			idx_s3 <= scaled[QW +: AW];
			inr_s3 <= (zz_s2[63:2*FRACTION_BITS+4] == '0);
			pt_s4  <= pt_s3;
			inr_s4 <= inr_s3;
			rom_s4 <= WROM[idx_s3];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/wpne_queue.sv */
// ----------------------------------------------------------------------------
// Weighted plane normal equations: decoupling queue
// Small first-in first-out buffer of weighted points between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module wpne_queue
	import wpne_pkg::*;
#(
	parameter int DEPTH = WPNE_QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  q_item_t wr_data,
	input  logic    rd,
	output q_item_t rd_data,
	output logic    full,
	output logic    empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_item_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/wpne_back.sv */
// ----------------------------------------------------------------------------
// Weighted plane normal equations: back end
// Forms the nine weighted terms of each point over pipelined product stages and
// adds them into saturating accumulators; the last point of a set loads the
// result register and clears the sums.
// ----------------------------------------------------------------------------
`default_nettype none

module wpne_back
	import wpne_pkg::*;
#(
	parameter int FRACTION_BITS = WPNE_FRACTION_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  q_item_t    q_item,
	output logic       q_pop,
	input  logic       pop,
	output logic       empty,
	output out_word_t  sums,
	output back_stat_t stat
);

	localparam int NUM_SUMS = 9;
	localparam int NP = 5;
	localparam int NL = 3;

	localparam int H00 = 0;
	localparam int H01 = 1;
	localparam int H02 = 2;
	localparam int H11 = 3;
	localparam int H12 = 4;
	localparam int H22 = 5;
	localparam int G0  = 6;
	localparam int G1  = 7;
	localparam int G2  = 8;

	localparam logic [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
	localparam logic [63:0] SUM_MIN = {1'b1, 63'd0};

	logic                        adv, fire;
	logic                        vld_s1, vld_s2, vld_s3, vld_s4;
	logic                        last_s1, last_s2, last_s3, last_s4;
	logic signed [31:0]          x_s1, y_s1, z_s1;
	logic [WEIGHT_W-1:0]         w_s1, w_s2, w_s3;
	logic signed [31:0]          opa [NP];
	logic signed [31:0]          opb [NP];
	logic signed [31:0]          opl [NL];
	logic signed [63:0]          p_s2 [NP];
	logic signed [63:0]          lin_s2 [NL];
	logic signed [63:0]          lin_s3 [NL];
	logic [WEIGHT_W+31:0]        lo_s3 [NP];
	logic signed [WEIGHT_W+32:0] hi_s3 [NP];
	logic signed [63:0]          term_d [NUM_SUMS];
	logic signed [63:0]          term_s4 [NUM_SUMS];
	logic [63:0]                 acc_q [NUM_SUMS];
	logic [63:0]                 nxt [NUM_SUMS];
	logic                        sat_any;
	logic                        ovf_q;
	logic                        out_vld_q;
	out_word_t                   out_q;

	assign adv        = !(vld_s4 && last_s4 && out_vld_q && !pop);
	assign fire       = vld_s4 && adv;
	assign q_pop      = adv && !q_empty;
	assign empty      = !out_vld_q;
	assign sums       = out_q;
	assign stat.emit  = fire && last_s4;
	assign stat.stall = !adv;

	assign opa[0] = y_s1;
	assign opb[0] = y_s1;
	assign opa[1] = x_s1;
	assign opb[1] = y_s1;
	assign opa[2] = x_s1;
	assign opb[2] = x_s1;
	assign opa[3] = z_s1;
	assign opb[3] = y_s1;
	assign opa[4] = z_s1;
	assign opb[4] = x_s1;
	assign opl[0] = y_s1;
	assign opl[1] = x_s1;
	assign opl[2] = z_s1;

	always_comb begin
		logic [63:0]        whole;
		logic signed [63:0] pp [NP];
		for (int k = 0; k < NP; k++) begin
			whole = {hi_s3[k][31:0], 32'd0} + 64'(lo_s3[k]);
			pp[k] = $signed(whole) >>> FRACTION_BITS;
		end
		term_d[H00] = $signed(64'(w_s3));
		term_d[H01] = lin_s3[0];
		term_d[H02] = -lin_s3[1];
		term_d[H11] = pp[0];
		term_d[H12] = -pp[1];
		term_d[H22] = pp[2];
		term_d[G0]  = lin_s3[2];
		term_d[G1]  = pp[3];
		term_d[G2]  = -pp[4];
	end

	always_comb begin
		logic [64:0] s;
		sat_any = 1'b0;
		for (int i = 0; i < NUM_SUMS; i++) begin
			s = {acc_q[i][63], acc_q[i]} + {term_s4[i][63], term_s4[i]};
			if (s[64] != s[63]) begin
				sat_any = 1'b1;
				nxt[i] = s[64] ? SUM_MIN : SUM_MAX;
			end else begin
				nxt[i] = s[63:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= !q_empty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= q_item.pt.px;
			y_s1    <= q_item.pt.py;
			z_s1    <= q_item.pt.pz;
			w_s1    <= q_item.weight;
			last_s1 <= q_item.pt.last_point;
			w_s2    <= w_s1;
			last_s2 <= last_s1;
			w_s3    <= w_s2;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			for (int k = 0; k < NP; k++) begin
				p_s2[k]  <= (opa[k] * opb[k]) >>> FRACTION_BITS;
				lo_s3[k] <= w_s2 * p_s2[k][31:0];
				hi_s3[k] <= $signed({1'b0, w_s2}) * $signed(p_s2[k][63:32]);
			end
			for (int k = 0; k < NL; k++) begin
				lin_s2[k] <= ($signed({1'b0, w_s1}) * opl[k]) >>> FRACTION_BITS;
				lin_s3[k] <= lin_s2[k];
			end
			for (int i = 0; i < NUM_SUMS; i++) begin
				term_s4[i] <= term_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SUMS; i++) begin
				acc_q[i] <= '0;
			end
			ovf_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (fire) begin
				for (int i = 0; i < NUM_SUMS; i++) begin
					acc_q[i] <= last_s4 ? '0 : nxt[i];
				end
				ovf_q <= last_s4 ? 1'b0 : (ovf_q | sat_any);
			end
			if (fire && last_s4) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s4) begin
			out_q.h_00       <= nxt[H00];
			out_q.h_01       <= nxt[H01];
			out_q.h_02       <= nxt[H02];
			out_q.h_11       <= nxt[H11];
			out_q.h_12       <= nxt[H12];
			out_q.h_22       <= nxt[H22];
			out_q.g_0        <= nxt[G0];
			out_q.g_1        <= nxt[G1];
			out_q.g_2        <= nxt[G2];
			out_q.overflowed <= ovf_q | sat_any;
		end
	end

endmodule

`default_nettype wire

/* tb/tb_weighted_plane_normal_equations_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted plane normal equations unit testbench
// Streams point sets into the unit and checks every emitted word of sums and
// the saturation flag against a predictor that rebuilds the weight table and
// the saturating accumulators, under randomized idling and back pressure.
// ----------------------------------------------------------------------------
import wpne_pkg::*;

class normal_eq_scoreboard;
	longint   weight_table[WPNE_ROM_DEPTH];
	longint   running_sum[9];
	bit       saturated;
	out_word_t expected_sums[$];
	int       errors;

	function new();
		bit [63:0] term, series, ratio, level;
		int n;
		int k;
		term = 64'd1 << 48;
		series = term;
		for (n = 1; n <= 20; n++) begin
			term = (term * 64'd16) / (64'(WPNE_ROM_DEPTH) * 64'(n));
			if (n % 2 == 1) series = series - term;
			else series = series + term;
		end
		ratio = (series + (64'd1 << 15)) >> 16;
		level = 64'd1 << 32;
		for (k = 0; k < WPNE_ROM_DEPTH; k++) begin
			if (k > 0) level = (level * ratio + (64'd1 << 31)) >> 32;
			weight_table[k] = longint'((level + (64'd1 << (31 - WPNE_FRACTION_BITS)))
				>> (32 - WPNE_FRACTION_BITS));
		end
		foreach (running_sum[i]) running_sum[i] = 0;
		saturated = 1'b0;
		errors = 0;
	endfunction

	function longint fix_floor(longint v);
		return v >>> WPNE_FRACTION_BITS;
	endfunction

	function longint weighted_product(longint w, longint a, longint b);
		return fix_floor(w * fix_floor(a * b));
	endfunction

	function void saturating_add(int i, longint t);
		longint s;
		s = running_sum[i] + t;
		if (running_sum[i][63] == t[63] && s[63] != t[63]) begin
			s = t[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
			saturated = 1'b1;
		end
		running_sum[i] = s;
	endfunction

	function void note_point(in_word_t p);
		longint x, y, z, w, sq, idx;
		out_word_t res;
		x = $signed(p.px);
		y = $signed(p.py);
		z = $signed(p.pz);
		w = 0;
		sq = (z * z) >>> WPNE_FRACTION_BITS;
		if ((sq >> (WPNE_FRACTION_BITS + 4)) == 0) begin
			idx = (sq * WPNE_ROM_DEPTH) >> (WPNE_FRACTION_BITS + 4);
			if (idx < WPNE_ROM_DEPTH) w = weight_table[idx];
		end
		saturating_add(0, w);
		saturating_add(1, fix_floor(w * y));
		saturating_add(2, -fix_floor(w * x));
		saturating_add(3, weighted_product(w, y, y));
		saturating_add(4, -weighted_product(w, x, y));
		saturating_add(5, weighted_product(w, x, x));
		saturating_add(6, fix_floor(w * z));
		saturating_add(7, weighted_product(w, z, y));
		saturating_add(8, -weighted_product(w, z, x));
		if (p.last_point) begin
			res.h_00 = running_sum[0];
			res.h_01 = running_sum[1];
			res.h_02 = running_sum[2];
			res.h_11 = running_sum[3];
			res.h_12 = running_sum[4];
			res.h_22 = running_sum[5];
			res.g_0 = running_sum[6];
			res.g_1 = running_sum[7];
			res.g_2 = running_sum[8];
			res.overflowed = saturated;
			expected_sums.push_back(res);
			foreach (running_sum[i]) running_sum[i] = 0;
			saturated = 1'b0;
		end
	endfunction

	function void compare_field(string name, longint want, longint got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	function void check_sums(out_word_t got);
		out_word_t want;
		if (expected_sums.size() == 0) begin
			errors++;
			$display("%0t: unexpected word: expected none, actual %h", $time, got);
			return;
		end
		want = expected_sums.pop_front();
		compare_field("h_00", want.h_00, got.h_00);
		compare_field("h_01", want.h_01, got.h_01);
		compare_field("h_02", want.h_02, got.h_02);
		compare_field("h_11", want.h_11, got.h_11);
		compare_field("h_12", want.h_12, got.h_12);
		compare_field("h_22", want.h_22, got.h_22);
		compare_field("g_0", want.g_0, got.g_0);
		compare_field("g_1", want.g_1, got.g_1);
		compare_field("g_2", want.g_2, got.g_2);
		compare_field("overflowed", want.overflowed, got.overflowed);
	endfunction

	function int pending();
		return expected_sums.size();
	endfunction
endclass

module tb_weighted_plane_normal_equations_unit;
	localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] ONE       = 32'sh0001_0000;
	localparam logic signed [31:0] Z_EDGE    = 32'sh0004_0000;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_word_t  point;
	logic      empty;
	logic      pop;
	out_word_t sums;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;

	normal_eq_scoreboard sb = new();

	weighted_plane_normal_equations_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.point(point),
		.empty(empty),
		.pop(pop),
		.sums(sums)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && push && !full) sb.note_point(point);
		if (arst_n && pop && !empty) sb.check_sums(sums);
	end

	initial begin
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_word(input logic signed [31:0] x, input logic signed [31:0] y,
		input logic signed [31:0] z, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		point <= '{px: x, py: y, pz: z, last_point: last};
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2, 3, 4: return $urandom;
			default: return $urandom_range(0, 32'd1310720) - 32'd655360;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_height();
		logic signed [31:0] v;
		case ($urandom_range(9))
			0: return $urandom;
			1: begin
				case ($urandom_range(3))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			2: begin
				v = Z_EDGE + $urandom_range(4) - 2;
				if ($urandom_range(1)) v = -v;
				return v;
			end
			default: return $urandom_range(0, 32'h0008_8000) - 32'h0004_4000;
		endcase
	endfunction

	task automatic send_random_sets(input int n_items);
		int sent;
		int set_len;
		int k;
		sent = 0;
		while (sent < n_items) begin
			set_len = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
			for (k = 0; k < set_len; k++)
				send_word(rand_coord(), rand_coord(), rand_height(), k == set_len - 1);
			sent += set_len;
		end
	endtask

	initial begin
		int k;
		arst_n <= 1'b0;
		push <= 1'b0;
		point <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(32'sd0, 32'sd0, 32'sd0, 1'b1);
		send_word(ONE, -ONE, ONE / 2, 1'b1);
		send_word(COORD_MAX, COORD_MAX, 32'sd0, 1'b0);
		send_word(COORD_MIN, COORD_MIN, -32'sd1, 1'b1);
		for (k = 0; k < 3; k++) send_word(COORD_MIN, 32'sd0, 32'sd0, k == 2);
		send_word(32'sd0, 32'sd0, 32'sd0, 1'b1);
		for (k = 0; k < 3; k++) send_word(COORD_MIN, COORD_MIN, 32'sd0, k == 2);
		send_word(ONE, 2 * ONE, Z_EDGE, 1'b1);
		send_word(ONE, 2 * ONE, Z_EDGE - 1, 1'b1);
		send_word(ONE, 2 * ONE, -Z_EDGE, 1'b1);
		send_word(-3 * ONE, -5 * ONE, -Z_EDGE + 1, 1'b1);
		send_word(ONE, ONE, COORD_MIN, 1'b0);
		send_word(ONE, ONE, COORD_MAX, 1'b1);
		send_word(-ONE, -7, -ONE, 1'b0);
		send_word(COORD_MAX, COORD_MIN, ONE, 1'b1);
		drain();

		send_idle_pct = 25;
		recv_idle_pct = 87;
		send_random_sets(600);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		for (k = 0; k < 40; k++) send_word(rand_coord(), rand_coord(), rand_height(), 1'b1);

		send_idle_pct = 87;
		recv_idle_pct = 25;
		send_random_sets(600);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_sets(600);
		drain();
		repeat (20) @(posedge clk);

		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
